// ===== design/wtfe_pkg.sv =====
// shared types and constants for the windowed trade feature engine
`default_nettype none

package wtfe_pkg;

  localparam int PRICE_W     = 24;
  localparam int QTY_W       = 24;
  localparam int TIME_W      = 48;
  localparam int CFG_W       = 7;
  localparam int RET_FRAC    = 24;
  localparam int RET_W       = 49;
  localparam int VWAP_FRAC   = 16;
  localparam int VWAP_W      = 40;
  localparam int IMB_FRAC    = 15;
  localparam int IMB_W       = 16;
  localparam int VOL_W       = 32;
  localparam int RATE_W      = 32;
  localparam int RATE_SCALE  = 256000;
  localparam int RATE_SCALE_W = 18;
  localparam int SQ_LO_W     = 25;
  localparam int MUL_W       = 25;
  localparam int SQRT_W      = 64;
  localparam int SQRT_STEPS  = 32;
  localparam int SQRT_CNT_W  = 5;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd64;
  localparam logic [IMB_W-1:0] IMB_MAX      = 16'h7fff;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic               side;
    logic [TIME_W-1:0]  tstamp;
    logic               rflag;
    logic [RET_W-1:0]   ret;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ===== design/windowed_trade_feature_engine.sv =====
// rolling trade window with vwap, imbalance, return volatility and trade rate
// work per trade: the shared one-bit-per-cycle divider (six divisions), the two walks
//   over the ring memory, which has one read port and one write port, and a 32-step
//   square root
// throughput: a new trade is taken only once the last one is done; the output register
//   lets the next trade start while a result waits
// reset: control, pointers and sums clear at once; ring contents stay undefined
`default_nettype none

module windowed_trade_feature_engine #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [wtfe_pkg::PRICE_W-1:0]        price,
  input  logic [wtfe_pkg::QTY_W-1:0]          quantity,
  input  logic                                buyer_is_maker,
  input  logic [wtfe_pkg::TIME_W-1:0]         timestamp,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [$clog2(MAX_WINDOW+1)-1:0]     count,
  output logic [wtfe_pkg::TIME_W-1:0]         last_time,
  output logic [wtfe_pkg::VWAP_W-1:0]         vwap,
  output logic signed [wtfe_pkg::IMB_W-1:0]   imbalance,
  output logic [wtfe_pkg::VOL_W-1:0]          volatility,
  output logic                                vol_valid,
  output logic [wtfe_pkg::RATE_W-1:0]         trade_freq,
  output logic                                rate_valid,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wtfe_pkg::CFG_W-1:0]          cfg_data
);
  import wtfe_pkg::*;

  localparam int AW      = $clog2(MAX_WINDOW);
  localparam int CW      = $clog2(MAX_WINDOW + 1);
  localparam int PVW     = PRICE_W + QTY_W + CW;
  localparam int VW      = QTY_W + CW;
  localparam int SUMW    = RET_W + CW;
  localparam int NW      = 2 * RET_W + CW;
  localparam int DNW     = TIME_W;
  localparam int LENW    = $clog2(NW + 1);
  localparam int L_RET   = PRICE_W + RET_FRAC;
  localparam int L_VWAP  = PVW + VWAP_FRAC;
  localparam int L_IMB   = VW + IMB_FRAC;
  localparam int L_RATE  = CW + RATE_SCALE_W;
  localparam int L_MEAN  = SUMW - 1;
  localparam int L_VAR   = NW;

  typedef enum logic [4:0] {
    ST_IDLE, ST_EV, ST_EVSUB, ST_PREV, ST_PREVW, ST_RDIV, ST_WRITE,
    ST_P1R, ST_P1A, ST_VWAP_S, ST_VWAP_W, ST_IMB_S, ST_IMB_W,
    ST_RATE_S, ST_RATE_W, ST_MEAN_S, ST_MEAN_W, ST_P2R, ST_P2A,
    ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_VAR_S, ST_VAR_W, ST_SQRT, ST_DONE
  } state_t;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW+1:0] s;
    s = (CW+2)'(a) + (CW+2)'(b);
    if (s >= (CW+2)'(MAX_WINDOW)) s = s - (CW+2)'(MAX_WINDOW);
    return AW'(s);
  endfunction

  state_t              state;
  logic [CFG_W-1:0]    window;
  logic [AW-1:0]       head;
  logic [CW-1:0]       fill;
  logic [PVW-1:0]      pv;
  logic [VW-1:0]       vol;
  logic [VW-1:0]       buy;

  logic [PRICE_W-1:0]  p_r;
  logic [QTY_W-1:0]    q_r;
  logic                s_r;
  logic [TIME_W-1:0]   t_r;
  logic                rflag;
  logic [RET_W-1:0]    ret_r;
  logic                ret_neg;
  logic                imb_neg;

  logic [AW-1:0]       ptr;
  logic [CW-1:0]       idx;
  logic [SUMW-1:0]     sum;
  logic [CW-1:0]       m;
  logic [TIME_W-1:0]   oldest;
  logic [RET_W-1:0]    mean;
  logic [RET_W-1:0]    mag;
  logic [NW-1:0]       acc;
  logic [SQRT_W-1:0]   sq_v;
  logic [SQRT_W-1:0]   sq_res;
  logic [SQRT_W-1:0]   sq_bit;
  logic [SQRT_CNT_W-1:0] sq_cnt;

  logic [VWAP_W-1:0]   r_vwap;
  logic [IMB_W-1:0]    r_imb;
  logic [VOL_W-1:0]    r_vol;
  logic                r_volv;
  logic [RATE_W-1:0]   r_rate;
  logic                r_ratev;

  logic [2*MUL_W-1:0]  prod;
  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;

  entry_t              mem [MAX_WINDOW];
  entry_t              rd;
  entry_t              wdata;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic                mem_we;

  logic                div_start;
  logic [NW-1:0]       div_num;
  logic [DNW-1:0]      div_den;
  logic [LENW-1:0]     div_len;
  div_status_t         div_st;
  logic [NW-1:0]       div_quo;

  logic [CW-1:0]       w_eff;
  logic                last;
  logic [PRICE_W-1:0]  pabs;
  logic [VW-1:0]       sell;
  logic                buy_ge;
  logic [VW-1:0]       diff;
  logic                rate_ok;
  logic [L_RATE-1:0]   rate_num;
  logic [SUMW-2:0]     sum_abs;
  logic signed [RET_W:0] dev;
  logic [SQRT_W-1:0]   sq_trial;
  logic                sq_ge;
  logic [SQRT_W-1:0]   sq_res_n;
  logic                out_free;

  wtfe_div #(.NUM_W(NW), .DEN_W(DNW), .LEN_W(LENW)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .len    (div_len),
    .status (div_st),
    .quo    (div_quo)
  );

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (window == '0) w_eff = CW'(1);
    else if (int'(window) > MAX_WINDOW) w_eff = CW'(MAX_WINDOW);
    else w_eff = CW'(window);
  end

  always_comb begin
    last     = (idx == CW'(fill - CW'(1)));
    pabs     = (p_r >= rd.price) ? p_r - rd.price : rd.price - p_r;
    sell     = vol - buy;
    buy_ge   = buy >= sell;
    diff     = buy_ge ? buy - sell : sell - buy;
    rate_ok  = (fill >= CW'(2)) && (t_r > oldest);
    rate_num = L_RATE'(fill) * L_RATE'(RATE_SCALE);
    sum_abs  = sum[SUMW-1] ? (SUMW-1)'(SUMW'(0) - sum) : sum[SUMW-2:0];
    dev      = $signed({rd.ret[RET_W-1], rd.ret}) - $signed({mean[RET_W-1], mean});
    sq_trial = sq_res + sq_bit;
    sq_ge    = sq_v >= sq_trial;
    sq_res_n = sq_ge ? (sq_res >> 1) + sq_bit : sq_res >> 1;
  end

  // memory address and write port
  always_comb begin
    mem_we = (state == ST_WRITE);
    waddr  = wrap_add(head, fill);
    wdata  = '{price: p_r, qty: q_r, side: s_r, tstamp: t_r, rflag: rflag, ret: ret_r};
    unique case (state)
      ST_IDLE: raddr = head;
      ST_PREV: raddr = wrap_add(head, CW'(fill - CW'(1)));
      default: raddr = ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  // shared multiplier operands
  always_comb begin
    unique case (state)
      ST_EV: begin
        mul_a = MUL_W'(rd.price);
        mul_b = MUL_W'(rd.qty);
      end
      ST_PREV: begin
        mul_a = MUL_W'(p_r);
        mul_b = MUL_W'(q_r);
      end
      ST_SQ0: begin
        mul_a = mag[SQ_LO_W-1:0];
        mul_b = mag[SQ_LO_W-1:0];
      end
      ST_SQ1: begin
        mul_a = mag[SQ_LO_W-1:0];
        mul_b = MUL_W'(mag[RET_W-1:SQ_LO_W]);
      end
      ST_SQ2: begin
        mul_a = MUL_W'(mag[RET_W-1:SQ_LO_W]);
        mul_b = MUL_W'(mag[RET_W-1:SQ_LO_W]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // divider requests, numerator left-aligned to its length
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_len   = LENW'(1);
    unique case (state)
      ST_PREVW: begin
        div_start = (fill != '0) && (rd.price != '0);
        div_num   = NW'({pabs, {RET_FRAC{1'b0}}}) << (NW - L_RET);
        div_den   = DNW'(rd.price);
        div_len   = LENW'(L_RET);
      end
      ST_VWAP_S: begin
        div_start = (vol != '0);
        div_num   = NW'({pv, {VWAP_FRAC{1'b0}}}) << (NW - L_VWAP);
        div_den   = DNW'(vol);
        div_len   = LENW'(L_VWAP);
      end
      ST_IMB_S: begin
        div_start = (vol != '0);
        div_num   = NW'({diff, {IMB_FRAC{1'b0}}}) << (NW - L_IMB);
        div_den   = DNW'(vol);
        div_len   = LENW'(L_IMB);
      end
      ST_RATE_S: begin
        div_start = rate_ok;
        div_num   = NW'(rate_num) << (NW - L_RATE);
        div_den   = t_r - oldest;
        div_len   = LENW'(L_RATE);
      end
      ST_MEAN_S: begin
        div_start = (m != '0);
        div_num   = NW'(sum_abs) << (NW - L_MEAN);
        div_den   = DNW'(m);
        div_len   = LENW'(L_MEAN);
      end
      ST_VAR_S: begin
        div_start = 1'b1;
        div_num   = acc;
        div_den   = DNW'(m);
        div_len   = LENW'(L_VAR);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      window    <= WINDOW_RESET;
      head      <= '0;
      fill      <= '0;
      pv        <= '0;
      vol       <= '0;
      buy       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) window <= cfg_data;
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            p_r <= price;
            q_r <= quantity;
            s_r <= buyer_is_maker;
            t_r <= timestamp;
            state <= (fill >= w_eff) ? ST_EV : ST_PREV;
          end
        end
        ST_EV: begin
          // take the oldest trade out of the running sums
          vol   <= vol - VW'(rd.qty);
          if (rd.side) buy <= buy - VW'(rd.qty);
          head  <= wrap_add(head, CW'(1));
          fill  <= fill - CW'(1);
          state <= ST_EVSUB;
        end
        ST_EVSUB: begin
          pv    <= pv - PVW'(prod);
          state <= ST_PREV;
        end
        ST_PREV: begin
          state <= ST_PREVW;
        end
        ST_PREVW: begin
          pv  <= pv + PVW'(prod);
          vol <= vol + VW'(q_r);
          if (s_r) buy <= buy + VW'(q_r);
          ret_neg <= p_r < rd.price;
          if (div_start) begin
            state <= ST_RDIV;
          end else begin
            rflag <= 1'b0;
            ret_r <= '0;
            state <= ST_WRITE;
          end
        end
        ST_RDIV: begin
          if (div_st.done) begin
            rflag <= 1'b1;
            ret_r <= ret_neg ? RET_W'(0) - div_quo[RET_W-1:0] : div_quo[RET_W-1:0];
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          fill  <= fill + CW'(1);
          ptr   <= head;
          idx   <= '0;
          sum   <= '0;
          m     <= '0;
          state <= ST_P1R;
        end
        ST_P1R: begin
          state <= ST_P1A;
        end
        ST_P1A: begin
          if (idx == '0) begin
            oldest <= rd.tstamp;
          end else if (rd.rflag) begin
            sum <= sum + {{(SUMW-RET_W){rd.ret[RET_W-1]}}, rd.ret};
            m   <= m + CW'(1);
          end
          if (last) begin
            state <= ST_VWAP_S;
          end else begin
            idx   <= idx + CW'(1);
            ptr   <= wrap_add(ptr, CW'(1));
            state <= ST_P1R;
          end
        end
        ST_VWAP_S: begin
          if (div_start) begin
            state <= ST_VWAP_W;
          end else begin
            r_vwap <= '0;
            state  <= ST_IMB_S;
          end
        end
        ST_VWAP_W: begin
          if (div_st.done) begin
            r_vwap <= div_quo[VWAP_W-1:0];
            state  <= ST_IMB_S;
          end
        end
        ST_IMB_S: begin
          imb_neg <= !buy_ge;
          if (div_start) begin
            state <= ST_IMB_W;
          end else begin
            r_imb <= '0;
            state <= ST_RATE_S;
          end
        end
        ST_IMB_W: begin
          if (div_st.done) begin
            if (imb_neg) r_imb <= IMB_W'(0) - div_quo[IMB_W-1:0];
            else if (div_quo > NW'(IMB_MAX)) r_imb <= IMB_MAX;
            else r_imb <= div_quo[IMB_W-1:0];
            state <= ST_RATE_S;
          end
        end
        ST_RATE_S: begin
          if (div_start) begin
            state <= ST_RATE_W;
          end else begin
            r_rate  <= '0;
            r_ratev <= 1'b0;
            state   <= ST_MEAN_S;
          end
        end
        ST_RATE_W: begin
          if (div_st.done) begin
            r_rate  <= (|div_quo[NW-1:RATE_W]) ? '1 : div_quo[RATE_W-1:0];
            r_ratev <= 1'b1;
            state   <= ST_MEAN_S;
          end
        end
        ST_MEAN_S: begin
          if (div_start) begin
            state <= ST_MEAN_W;
          end else begin
            r_vol  <= '0;
            r_volv <= 1'b0;
            state  <= ST_DONE;
          end
        end
        ST_MEAN_W: begin
          if (div_st.done) begin
            mean  <= sum[SUMW-1] ? RET_W'(0) - div_quo[RET_W-1:0] : div_quo[RET_W-1:0];
            acc   <= '0;
            ptr   <= head;
            idx   <= '0;
            state <= ST_P2R;
          end
        end
        ST_P2R: begin
          state <= ST_P2A;
        end
        ST_P2A: begin
          mag <= dev[RET_W] ? RET_W'(-dev) : RET_W'(dev);
          if ((idx != '0) && rd.rflag) begin
            state <= ST_SQ0;
          end else if (last) begin
            state <= ST_VAR_S;
          end else begin
            idx   <= idx + CW'(1);
            ptr   <= wrap_add(ptr, CW'(1));
            state <= ST_P2R;
          end
        end
        ST_SQ0: begin
          state <= ST_SQ1;
        end
        // square in three partial products: lo*lo, 2*lo*hi, hi*hi
        ST_SQ1: begin
          acc   <= acc + NW'(prod);
          state <= ST_SQ2;
        end
        ST_SQ2: begin
          acc   <= acc + (NW'(prod) << (SQ_LO_W + 1));
          state <= ST_SQ3;
        end
        ST_SQ3: begin
          acc <= acc + (NW'(prod) << (2 * SQ_LO_W));
          if (last) begin
            state <= ST_VAR_S;
          end else begin
            idx   <= idx + CW'(1);
            ptr   <= wrap_add(ptr, CW'(1));
            state <= ST_P2R;
          end
        end
        ST_VAR_S: begin
          state <= ST_VAR_W;
        end
        ST_VAR_W: begin
          if (div_st.done) begin
            r_volv <= 1'b1;
            if (|div_quo[NW-1:SQRT_W]) begin
              r_vol <= '1;
              state <= ST_DONE;
            end else begin
              sq_v   <= div_quo[SQRT_W-1:0];
              sq_res <= '0;
              sq_bit <= SQRT_W'(1) << (SQRT_W - 2);
              sq_cnt <= '0;
              state  <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          if (sq_ge) sq_v <= sq_v - sq_trial;
          sq_res <= sq_res_n;
          sq_bit <= sq_bit >> 2;
          sq_cnt <= sq_cnt + SQRT_CNT_W'(1);
          if (sq_cnt == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
            r_vol <= sq_res_n[VOL_W-1:0];
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            count      <= fill;
            last_time  <= t_r;
            vwap       <= r_vwap;
            imbalance  <= r_imb;
            volatility <= r_vol;
            vol_valid  <= r_volv;
            trade_freq <= r_rate;
            rate_valid <= r_ratev;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_div_start_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(MAX_WINDOW))
    else $error("ring fill above depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("trade transfer did not start processing");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != '0))
    else $error("result with empty window");

endmodule

`default_nettype wire

// ===== design/wtfe_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle, caller-set length
`default_nettype none

module wtfe_div #(
  parameter int NUM_W = 106,
  parameter int DEN_W = 48,
  parameter int LEN_W = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [NUM_W-1:0]      num,
  input  logic [DEN_W-1:0]      den,
  input  logic [LEN_W-1:0]      len,
  output wtfe_pkg::div_status_t status,
  output logic [NUM_W-1:0]      quo
);
  import wtfe_pkg::*;

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [LEN_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial = {rem, quo[NUM_W-1]};
    ge    = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= num;
        dsr  <= den;
        cnt  <= len;
      end else if (busy) begin
        rem <= ge ? DEN_W'(trial - {1'b0, dsr}) : DEN_W'(trial);
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt - LEN_W'(1);
        if (cnt == LEN_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

`default_nettype wire
